>>> hdl/base64_stream_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// base64_stream_decoder_top_assert
// Assertion macros for the base64 stream decoder. Expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_TOP_ASSERT_SVH
`define BASE64_STREAM_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define B64SD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define B64SD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/b64sd_pkg.sv
// ----------------------------------------------------------------------------
// b64sd_pkg
// Types, constants and helpers shared by the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64sd_pkg;

  localparam int COUNT_BITS   = 16;
  localparam int SYM_W        = 8;
  localparam int KIND_W       = 2;
  localparam int OUT_CNT_W    = 16;
  localparam int LIMIT_W      = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int MAX_RESULTS  = 3;
  localparam int QUEUE_DEPTH  = 8;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 2'd1;

  localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FAIL = 2'd2;

  localparam logic [SYM_W-1:0] PAD_CHAR  = 8'h3D;
  localparam logic [6:0]       NO_SEXTET = 7'd64;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic [KIND_W-1:0]    kind;
    logic [OUT_CNT_W-1:0] byte_count;
    logic                 last;
  } result_t;

  function automatic logic [6:0] sextet_of(input logic [SYM_W-1:0] c);
    logic [6:0] s;
    s = NO_SEXTET;
    if (c >= 8'h41 && c <= 8'h5A) s = 7'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) s = 7'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) s = 7'(c - 8'h30 + 8'd52);
    else if (c == 8'h2B) s = 7'd62;
    else if (c == 8'h2F) s = 7'd63;
    return s;
  endfunction

  function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [COUNT_BITS-1:0] c);
    logic [32:0] w;
    w = 33'(c);
    return (w > 33'(16'hFFFF)) ? 16'hFFFF : w[OUT_CNT_W-1:0];
  endfunction

endpackage

>>> hdl/b64sd_in_if.sv
// ----------------------------------------------------------------------------
// b64sd_in_if
// Character channel into the base64 stream decoder.
// ----------------------------------------------------------------------------
interface b64sd_in_if;
  import b64sd_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             end_of_text;

  modport source(output valid, symbol, end_of_text, input ready);
  modport sink(input valid, symbol, end_of_text, output ready);
endinterface

>>> hdl/b64sd_out_if.sv
// ----------------------------------------------------------------------------
// b64sd_out_if
// Result channel out of the base64 stream decoder.
// ----------------------------------------------------------------------------
interface b64sd_out_if;
  import b64sd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [7:0]           out_byte;
  logic [KIND_W-1:0]    kind;
  logic [OUT_CNT_W-1:0] byte_count;
  logic                 last;

  modport source(output valid, out_byte, kind, byte_count, last, input ready);
  modport sink(input valid, out_byte, kind, byte_count, last, output ready);
endinterface

>>> hdl/b64sd_cfg_if.sv
// ----------------------------------------------------------------------------
// b64sd_cfg_if
// Register write channel of the base64 stream decoder.
// ----------------------------------------------------------------------------
interface b64sd_cfg_if;
  import b64sd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> hdl/base64_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Base64 decoder: one character a transfer in, one byte or status a transfer out.
// ----------------------------------------------------------------------------
// in_ch carries one character per transfer, or an end marker that closes the
// string. Every fourth character completes a group and yields up to three data
// results; the end marker yields one status result (done or failed, byte count,
// last set) and returns the decoder to its start state.
// cfg_ch writes limit_enable (index 0) and output_limit (index 1); it is always
// ready. Write it only while the decoder is idle.
// Results are queued by the transfer that causes them and offered on out_ch
// in order. Throughput: one character per cycle while in_ch.ready is high, set
// by the single decode stage; results drain one per cycle from an eight-entry
// result queue while out_ch.ready is high. in_ch.ready is low while fewer than
// three queue entries are free, so the results of a group always fit.
// Reset clears the decode state and the queue, sets limit_enable to 0 and
// output_limit to 65535.
`include "base64_stream_decoder_top_assert.svh"

module base64_stream_decoder_top (
  input  logic          clk,
  input  logic          rst_n,
  b64sd_in_if.sink      in_ch,
  b64sd_out_if.source   out_ch,
  b64sd_cfg_if.sink     cfg_ch
);
  import b64sd_pkg::*;

  logic                  limit_en_r;
  logic [LIMIT_W-1:0]    out_limit_r;

  logic [1:0]            pos_r, pos_nxt;
  logic [23:0]           gv_r, gv_nxt;
  logic [2:0]            pad_r, pad_nxt;
  logic [COUNT_BITS-1:0] bw_r, bw_nxt;
  logic                  stop_r, stop_nxt;
  logic                  err_r, err_nxt;

  result_t               q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]       cnt_r, cnt_nxt;

  logic                  in_fire, out_fire, cfg_fire;
  logic [1:0]            push_n;
  result_t               push_res [MAX_RESULTS];

  logic [6:0]            sx;
  logic                  is_pad;
  logic [23:0]           gv_acc;
  logic [2:0]            pad_acc;
  logic [32:0]           bw_ext, lim_ext, diff;
  logic [1:0]            room, due, emit;
  logic [COUNT_BITS:0]   bw_sum;

  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_fire = out_ch.valid & out_ch.ready;
  assign cfg_fire = cfg_ch.valid & cfg_ch.ready;

  assign in_ch.ready  = (cnt_r <= (QPTR_W+1)'(QUEUE_DEPTH - MAX_RESULTS));
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = (cnt_r != '0);
  assign out_ch.out_byte   = q_r[rd_ptr_r].out_byte;
  assign out_ch.kind       = q_r[rd_ptr_r].kind;
  assign out_ch.byte_count = q_r[rd_ptr_r].byte_count;
  assign out_ch.last       = q_r[rd_ptr_r].last;

  assign sx      = sextet_of(in_ch.symbol);
  assign is_pad  = (in_ch.symbol == PAD_CHAR);
  assign bw_ext  = 33'(bw_r);
  assign lim_ext = 33'(out_limit_r);
  assign diff    = lim_ext - bw_ext;

  always_comb begin
    if (!limit_en_r) begin
      room = 2'd3;
    end else if (bw_ext >= lim_ext) begin
      room = 2'd0;
    end else if (diff >= 33'd3) begin
      room = 2'd3;
    end else begin
      room = diff[1:0];
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    gv_nxt   = gv_r;
    pad_nxt  = pad_r;
    bw_nxt   = bw_r;
    stop_nxt = stop_r;
    err_nxt  = err_r;
    push_n   = 2'd0;
    gv_acc   = gv_r;
    pad_acc  = pad_r;
    due      = 2'd0;
    emit     = 2'd0;
    bw_sum   = '0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      push_res[k] = '{out_byte: 8'd0, kind: KIND_DATA, byte_count: '0, last: 1'b0};
    end
    if (in_fire) begin
      if (in_ch.end_of_text) begin
        push_n = 2'd1;
        push_res[0].kind = (err_r || (!stop_r && pos_r != 2'd0)) ? KIND_FAIL : KIND_DONE;
        push_res[0].byte_count = sat_count(bw_r);
        push_res[0].last = 1'b1;
        pos_nxt  = '0;
        gv_nxt   = '0;
        pad_nxt  = '0;
        bw_nxt   = '0;
        stop_nxt = 1'b0;
        err_nxt  = 1'b0;
      end else if (!err_r && !stop_r) begin
        if (pos_r == 2'd0 && !is_pad && sx == NO_SEXTET) begin
          stop_nxt = 1'b1;
        end else if (!is_pad && (pad_r != 3'd0 || sx == NO_SEXTET)) begin
          err_nxt = 1'b1;
        end else begin
          if (is_pad) begin
            pad_acc = (pad_r == 3'd7) ? pad_r : pad_r + 3'd1;
            gv_acc  = {gv_r[17:0], 6'd0};
          end else begin
            gv_acc  = {gv_r[17:0], sx[5:0]};
          end
          gv_nxt  = gv_acc;
          pad_nxt = pad_acc;
          if (pos_r != 2'd3) begin
            pos_nxt = pos_r + 2'd1;
          end else begin
            pos_nxt = '0;
            gv_nxt  = '0;
            pad_nxt = '0;
            if (pad_acc > 3'd2) begin
              err_nxt = 1'b1;
            end else begin
              due  = 2'(3'd3 - pad_acc);
              emit = (room < due) ? room : due;
              if (room < due) err_nxt = 1'b1;
              push_n = emit;
              bw_sum = {1'b0, bw_r} + (COUNT_BITS+1)'(emit);
              bw_nxt = bw_sum[COUNT_BITS] ? '1 : bw_sum[COUNT_BITS-1:0];
              push_res[0].out_byte = gv_acc[23:16];
              push_res[1].out_byte = gv_acc[15:8];
              push_res[2].out_byte = gv_acc[7:0];
            end
          end
        end
      end
    end
  end

  assign cnt_nxt = cnt_r + (QPTR_W+1)'(push_n) - (QPTR_W+1)'(out_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_en_r  <= 1'b0;
      out_limit_r <= 16'hFFFF;
      pos_r       <= '0;
      gv_r        <= '0;
      pad_r       <= '0;
      bw_r        <= '0;
      stop_r      <= 1'b0;
      err_r       <= 1'b0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_fire) begin
        case (cfg_ch.index)
          REG_LIMIT_ENABLE: limit_en_r  <= cfg_ch.data[0];
          REG_OUTPUT_LIMIT: out_limit_r <= cfg_ch.data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      pos_r    <= pos_nxt;
      gv_r     <= gv_nxt;
      pad_r    <= pad_nxt;
      bw_r     <= bw_nxt;
      stop_r   <= stop_nxt;
      err_r    <= err_nxt;
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push_n);
      if (out_fire) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (2'(k) < push_n) q_r[QPTR_W'(wr_ptr_r + QPTR_W'(k))] <= push_res[k];
    end
  end

  `B64SD_ASSERT_IMPLY(a_queue_bound, 1'b1, cnt_r <= (QPTR_W+1)'(QUEUE_DEPTH),
    "result queue overfilled")
  `B64SD_ASSERT_NEXT(a_status_push, in_fire && in_ch.end_of_text && !out_fire,
    cnt_r == $past(cnt_r) + 1'b1, "end marker did not queue one status")
  `B64SD_ASSERT_NEXT(a_string_clear, in_fire && in_ch.end_of_text,
    pos_r == '0 && bw_r == '0 && !err_r && !stop_r, "state not cleared after end")
  `B64SD_ASSERT_IMPLY(a_no_data_after_err, in_fire && !in_ch.end_of_text && (err_r || stop_r),
    push_n == 2'd0, "data queued after error or stop")

endmodule

>>> test/base64_stream_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_top_tb
// Self-checking bench for the base64 stream decoder.
// Drives characters and end markers into the decoder and predicts every data
// and status result in step with each accepted transfer. Covers the alphabet
// and padding, quiet stops, group errors, the output limit and a long receiver
// hold-off, with random idling on both channels.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b64sd_pkg::*;

  localparam int CYCLE_LIMIT  = 50_000;
  localparam int RANDOM_ITEMS = 170;

  logic clk;
  logic rst_n;

  b64sd_in_if  in_ch();
  b64sd_out_if out_ch();
  b64sd_cfg_if cfg_ch();

  base64_stream_decoder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  logic [1:0]            grp_pos;
  logic [23:0]           grp_bits;
  logic [2:0]            pad_seen;
  logic [COUNT_BITS-1:0] bytes_out;
  logic                  halted;
  logic                  failed;
  logic                  lim_on;
  logic [LIMIT_W-1:0]    lim_max;

  result_t decoded_q[$];

  int err_count;
  int cycle_count;
  int live_items;
  int hold_left;
  int rx_stall_left;
  bit tx_gaps;
  bit rx_gaps;

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    err_count++;
    if (err_count <= 40)
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
  endtask

  function automatic logic [6:0] sextet_value(input logic [7:0] c);
    case (c) inside
      [8'h41:8'h5A]: return 7'(c - 8'h41);
      [8'h61:8'h7A]: return 7'(c - 8'h47);
      [8'h30:8'h39]: return 7'(c + 8'h04);
      8'h2B:         return 7'd62;
      8'h2F:         return 7'd63;
      default:       return NO_SEXTET;
    endcase
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) return 8'h41 + w;
    if (v < 6'd52) return 8'h61 + w - 8'd26;
    if (v < 6'd62) return 8'h30 + w - 8'd52;
    if (v == 6'd62) return 8'h2B;
    return 8'h2F;
  endfunction

  function automatic logic [7:0] foreign_char();
    logic [7:0] c;
    do
      c = 8'($urandom_range(0, 255));
    while (sextet_value(c) != NO_SEXTET || c == PAD_CHAR);
    return c;
  endfunction

  task automatic clear_string_state();
    grp_pos   = '0;
    grp_bits  = '0;
    pad_seen  = '0;
    bytes_out = '0;
    halted    = 1'b0;
    failed    = 1'b0;
  endtask

  task automatic push_data(input logic [7:0] b);
    result_t r;
    if (failed) return;
    if (lim_on && bytes_out >= lim_max) begin
      failed = 1'b1;
      return;
    end
    r.out_byte   = b;
    r.kind       = KIND_DATA;
    r.byte_count = '0;
    r.last       = 1'b0;
    decoded_q.push_back(r);
    if (bytes_out != '1) bytes_out++;
  endtask

  task automatic predict_item(input logic [7:0] sym, input logic eot, output bit live);
    result_t    r;
    logic [6:0] sx;
    logic       is_pad;
    live = 1'b1;
    if (eot) begin
      if (!failed && !halted && grp_pos != 2'd0) failed = 1'b1;
      r.out_byte   = '0;
      r.kind       = failed ? KIND_FAIL : KIND_DONE;
      r.byte_count = OUT_CNT_W'(bytes_out);
      r.last       = 1'b1;
      decoded_q.push_back(r);
      clear_string_state();
      return;
    end
    if (failed || halted) begin
      live = 1'b0;
      return;
    end
    sx     = sextet_value(sym);
    is_pad = (sym == PAD_CHAR);
    if (grp_pos == 2'd0 && !is_pad && sx == NO_SEXTET) begin
      halted = 1'b1;
      return;
    end
    if (is_pad) begin
      if (pad_seen < 3'd7) pad_seen++;
      grp_bits = {grp_bits[17:0], 6'd0};
    end else if (pad_seen != 3'd0 || sx == NO_SEXTET) begin
      failed = 1'b1;
      return;
    end else begin
      grp_bits = {grp_bits[17:0], sx[5:0]};
    end
    if (grp_pos != 2'd3) begin
      grp_pos++;
      return;
    end
    grp_pos = 2'd0;
    if (pad_seen > 3'd2) begin
      failed = 1'b1;
    end else begin
      push_data(grp_bits[23:16]);
      if (pad_seen < 3'd2) push_data(grp_bits[15:8]);
      if (pad_seen == 3'd0) push_data(grp_bits[7:0]);
    end
    grp_bits = '0;
    pad_seen = '0;
  endtask

  task automatic send_item(input logic [7:0] sym, input logic eot);
    bit live;
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.symbol      <= sym;
    in_ch.end_of_text <= eot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(sym, eot, live);
    if (live) live_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_group(input int pads);
    for (int i = 0; i < 4; i++) begin
      if (i >= 4 - pads) send_item(PAD_CHAR, 1'b0);
      else send_item(sextet_char(6'($urandom_range(0, 63))), 1'b0);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_LIMIT_ENABLE) lim_on = val[0];
    else if (idx == REG_OUTPUT_LIMIT) lim_max = LIMIT_W'(val);
    @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        rx_stall_left = $urandom_range(0, 10);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (decoded_q.size() == 0) begin
        report("unexpected result, kind", 32'(out_ch.kind), 32'(KIND_DATA));
      end else begin
        want = decoded_q.pop_front();
        if (out_ch.out_byte !== want.out_byte)
          report("out_byte", 32'(out_ch.out_byte), 32'(want.out_byte));
        if (out_ch.kind !== want.kind)
          report("kind", 32'(out_ch.kind), 32'(want.kind));
        if (out_ch.byte_count !== want.byte_count)
          report("byte_count", 32'(out_ch.byte_count), 32'(want.byte_count));
        if (out_ch.last !== want.last)
          report("last", 32'(out_ch.last), 32'(want.last));
      end
    end
  end

  task automatic test_alphabet_and_padding();
    send_text("Az9/");
    send_text("+Q==");
    send_end();
    settle();
  endtask

  task automatic test_quiet_stop();
    send_item(8'h00, 1'b0);
    send_text("A");
    send_end();
    settle();
  endtask

  task automatic test_foreign_in_group();
    send_text("A");
    send_item(8'hFF, 1'b0);
    send_end();
    settle();
  endtask

  task automatic test_leading_pad();
    send_text("=A");
    send_end();
    settle();
  endtask

  task automatic test_excess_pads();
    send_text("A===");
    send_end();
    settle();
  endtask

  task automatic test_truncated_group();
    send_text("AB");
    send_end();
    settle();
  endtask

  task automatic test_output_limit();
    write_reg(REG_LIMIT_ENABLE, 16'd1);
    write_reg(REG_OUTPUT_LIMIT, 16'd1);
    send_text("AAAA");
    send_end();
    settle();
    write_reg(REG_LIMIT_ENABLE, 16'd0);
  endtask

  task automatic send_random_string();
    int groups;
    int mode;
    int k;
    groups = $urandom_range(0, 5);
    mode   = $urandom_range(0, 9);
    if (mode <= 5) begin
      for (int g = 0; g < groups; g++)
        send_group((g == groups - 1) ? $urandom_range(0, 2) : 0);
    end else if (mode == 6) begin
      repeat ($urandom_range(1, 10)) send_item(8'($urandom_range(0, 255)), 1'b0);
    end else if (mode == 7) begin
      for (int g = 0; g < groups; g++) send_group(0);
      k = $urandom_range(0, 4);
      if (k == 0) begin
        send_item(sextet_char(6'($urandom_range(0, 63))), 1'b0);
        send_item(foreign_char(), 1'b0);
      end else if (k == 1) begin
        send_item(sextet_char(6'($urandom_range(0, 63))), 1'b0);
        send_item(PAD_CHAR, 1'b0);
        send_item(sextet_char(6'($urandom_range(0, 63))), 1'b0);
      end else if (k == 2) begin
        repeat ($urandom_range(1, 3)) send_item(sextet_char(6'($urandom_range(0, 63))), 1'b0);
      end else if (k == 3) begin
        send_group($urandom_range(3, 4));
      end else begin
        send_item(PAD_CHAR, 1'b0);
        send_item(sextet_char(6'($urandom_range(0, 63))), 1'b0);
      end
    end else if (mode == 8) begin
      for (int g = 0; g < groups; g++) send_group(0);
      send_item(foreign_char(), 1'b0);
      repeat ($urandom_range(1, 4)) send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 7) == 0) send_item(PAD_CHAR, 1'b0);
        else send_item(sextet_char(6'($urandom_range(0, 63))), 1'b0);
      end
    end
    send_end();
  endtask

  task automatic test_random_strings();
    int target;
    int pick;
    target = live_items + RANDOM_ITEMS;
    while (live_items < target) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        write_reg(REG_LIMIT_ENABLE, 16'($urandom_range(0, 1)));
        pick = $urandom_range(0, 3);
        if (pick == 0) write_reg(REG_OUTPUT_LIMIT, 16'd0);
        else if (pick == 1) write_reg(REG_OUTPUT_LIMIT, 16'hFFFF);
        else write_reg(REG_OUTPUT_LIMIT, 16'($urandom_range(0, 24)));
      end
      send_random_string();
    end
    settle();
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    write_reg(REG_LIMIT_ENABLE, 16'd0);
    hold_left = 200;
    repeat (16) send_group(0);
    send_end();
    settle();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.symbol       = '0;
    in_ch.end_of_text  = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    err_count          = 0;
    cycle_count        = 0;
    live_items         = 0;
    hold_left          = 0;
    rx_stall_left      = 0;
    tx_gaps            = 1'b1;
    rx_gaps            = 1'b1;
    lim_on             = 1'b0;
    lim_max            = 16'hFFFF;
    clear_string_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_alphabet_and_padding();
    test_quiet_stop();
    test_foreign_in_group();
    test_leading_pad();
    test_excess_pads();
    test_truncated_group();
    test_output_limit();
    test_random_strings();
    test_backpressure();

    repeat (16) @(posedge clk);
    if (decoded_q.size() != 0) report("results missing", 32'd0, 32'(decoded_q.size()));
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
